FILE: rtl/pbb_pkg.sv
// Shared types and constants for the particle box bounce block.
package pbb_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned DIST_W = VAL_W + 1;
  localparam int unsigned DAMP_W = 17;
  localparam int unsigned PROD_W = VAL_W + DAMP_W;

  // 0.8 as unsigned Q0.16, with a zero sign bit
  localparam logic [DAMP_W-1:0] DAMP_Q16 = 17'd52429;
  localparam logic [PROD_W-1:0] DAMP_RND = 49'd32768;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    REG_RECT_LEFT   = 2'd0,
    REG_RECT_TOP    = 2'd1,
    REG_RECT_RIGHT  = 2'd2,
    REG_RECT_BOTTOM = 2'd3
  } pbb_reg_idx_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] top;
    logic signed [VAL_W-1:0] right;
    logic signed [VAL_W-1:0] bottom;
  } pbb_rect_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
  } pbb_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_pos_x;
    logic signed [VAL_W-1:0] new_pos_y;
    logic signed [VAL_W-1:0] new_vel_x;
    logic signed [VAL_W-1:0] new_vel_y;
    logic                    hit;
  } pbb_res_t;

endpackage

FILE: rtl/particle_box_bounce_top.sv
// Particle box bounce: top level with input register, response logic and result register.
//
// One particle word is taken every cycle while out_ready is high. A word passes through
// two registers, the input register and then the result register; the response logic
// (edge compares, nearest-edge choice and the 0.8 damping multiply) sits between
// them. in_ready follows out_ready combinationally, so the block keeps full
// throughput while the result side takes every word. Rectangle registers are
// written through the cfg_ port and must only be changed while no word is in
// flight. Particles strictly inside the rectangle are clamped to the nearest
// edge with damped outward velocity and hit set; others pass unchanged.
module particle_box_bounce_top
  import pbb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [VAL_W-1:0]        cfg_wdata,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_pos_x,
  input  logic signed [VAL_W-1:0] in_pos_y,
  input  logic signed [VAL_W-1:0] in_vel_x,
  input  logic signed [VAL_W-1:0] in_vel_y,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_new_pos_x,
  output logic signed [VAL_W-1:0] out_new_pos_y,
  output logic signed [VAL_W-1:0] out_new_vel_x,
  output logic signed [VAL_W-1:0] out_new_vel_y,
  output logic                    out_hit
);

  pbb_rect_t rect_r;
  pbb_in_t   s1_r;
  logic      s1_vld_r;
  pbb_res_t  res_nxt;
  pbb_res_t  res_r;
  logic      res_vld_r;
  logic      res_adv;
  logic      s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r <= '0;
    end else if (cfg_we) begin
      case (pbb_reg_idx_t'(cfg_index))
        REG_RECT_LEFT:   rect_r.left   <= cfg_wdata;
        REG_RECT_TOP:    rect_r.top    <= cfg_wdata;
        REG_RECT_RIGHT:  rect_r.right  <= cfg_wdata;
        REG_RECT_BOTTOM: rect_r.bottom <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign res_adv  = !res_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && res_adv;
  assign in_ready = !s1_vld_r || res_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r.pos_x <= in_pos_x;
      s1_r.pos_y <= in_pos_y;
      s1_r.vel_x <= in_vel_x;
      s1_r.vel_y <= in_vel_y;
    end
  end

  pbb_resp u_resp (
    .rect (rect_r),
    .item (s1_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_adv) begin
      res_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = res_vld_r;
  assign out_new_pos_x = res_r.new_pos_x;
  assign out_new_pos_y = res_r.new_pos_y;
  assign out_new_vel_x = res_r.new_vel_x;
  assign out_new_vel_y = res_r.new_vel_y;
  assign out_hit       = res_r.hit;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_s1_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> res_vld_r)
    else $error("word lost moving into result register");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !res_adv) |=> (s1_vld_r && $stable(s1_r)))
    else $error("stalled input stage changed");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && out_ready && !s1_vld_r) |=> !res_vld_r)
    else $error("result repeated after delivery");

endmodule

FILE: rtl/pbb_resp.sv
// Collision test, nearest-edge choice, clamp and damping for one word.
module pbb_resp
  import pbb_pkg::*;
(
  input  pbb_rect_t rect,
  input  pbb_in_t   item,
  output pbb_res_t  res
);

  logic signed [DIST_W-1:0] dl, dr, dt, db;
  logic                     in_box;
  logic                     pick_l, pick_r, pick_t;
  logic signed [VAL_W-1:0]  vx_f, vy_f;

  function automatic logic signed [VAL_W-1:0] force_pos(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v == {1'b1, {(VAL_W-1){1'b0}}}) begin
      r = VAL_MAX;
    end else if (v < 0) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] force_neg(input logic signed [VAL_W-1:0] v);
    return (v > 0) ? -v : v;
  endfunction

  function automatic logic signed [VAL_W-1:0] damp(input logic signed [VAL_W-1:0] v);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(v) * $signed({{(PROD_W-DAMP_W){1'b0}}, DAMP_Q16});
    p = p + $signed(DAMP_RND);
    return p[VAL_W+15:16];
  endfunction

  always_comb begin
    dl = DIST_W'(item.pos_x) - DIST_W'(rect.left);
    dr = DIST_W'(rect.right) - DIST_W'(item.pos_x);
    dt = DIST_W'(item.pos_y) - DIST_W'(rect.top);
    db = DIST_W'(rect.bottom) - DIST_W'(item.pos_y);

    in_box = (item.pos_x > rect.left) && (item.pos_x < rect.right) &&
             (item.pos_y > rect.top)  && (item.pos_y < rect.bottom);

    pick_l = (dl < dr) && (dl < dt) && (dl < db);
    pick_r = !pick_l && (dr < dl) && (dr < dt) && (dr < db);
    pick_t = !pick_l && !pick_r && (dt < dl) && (dt < dr) && (dt < db);

    res.new_pos_x = item.pos_x;
    res.new_pos_y = item.pos_y;
    vx_f          = item.vel_x;
    vy_f          = item.vel_y;
    if (pick_l) begin
      vx_f          = force_neg(item.vel_x);
      res.new_pos_x = rect.left;
    end else if (pick_r) begin
      vx_f          = force_pos(item.vel_x);
      res.new_pos_x = rect.right;
    end else if (pick_t) begin
      vy_f          = force_neg(item.vel_y);
      res.new_pos_y = rect.top;
    end else begin
      vy_f          = force_pos(item.vel_y);
      res.new_pos_y = rect.bottom;
    end

    if (in_box) begin
      res.new_vel_x = damp(vx_f);
      res.new_vel_y = damp(vy_f);
      res.hit       = 1'b1;
    end else begin
      res.new_pos_x = item.pos_x;
      res.new_pos_y = item.pos_y;
      res.new_vel_x = item.vel_x;
      res.new_vel_y = item.vel_y;
      res.hit       = 1'b0;
    end
  end

endmodule
